// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/wsdf_pkg.sv =====
package wsdf_pkg;

  localparam int unsigned LEN_W = 24;

  localparam logic [LEN_W-1:0] MAX_MSG_RESET = 24'd4194304;

  // Result kinds
  localparam logic [1:0] KIND_MSG   = 2'd0;
  localparam logic [1:0] KIND_PING  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;
  localparam logic [1:0] KIND_VIOL  = 2'd3;

  // Message types
  localparam logic [1:0] MSG_NONE   = 2'd0;
  localparam logic [1:0] MSG_TEXT   = 2'd1;
  localparam logic [1:0] MSG_BINARY = 2'd2;

  // Frame opcodes
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;

  // Second header byte length codes
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [3:0] EXT_BYTES_16 = 4'd2;
  localparam logic [3:0] EXT_BYTES_64 = 4'd8;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       new_connection;
  } wsdf_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] message_type;
    logic       has_byte;
    logic [7:0] data_byte;
    logic       begins;
    logic       is_last;
  } wsdf_out_t;

endpackage

// ===== rtl/core/websocket_frame_deframer_unit.sv =====
// WebSocket receive-side deframer: takes one received byte per transaction and
// gives at most one result per byte, registered, in the cycle after the byte
// is accepted. Sustained rate is one byte per clock, set by the single parser
// state update done in the accept cycle. The output register is refilled only
// when empty or draining, so a result held there by a low out_ready also holds
// off the next byte. Header, length and mask bytes produce no result, except a
// protocol violation or the marker of an empty frame. After a close event or a
// protocol violation all bytes are dropped until a byte arrives with
// new_connection set, which clears the parser (not max_bytes_r) before that
// byte is parsed. Write cfg_wdata only while no transaction is in flight.
`include "assert_macros.svh"

module websocket_frame_deframer_unit
  import wsdf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  wsdf_in_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output wsdf_out_t        out_data,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_MASK,
    PH_PAYLOAD,
    PH_HALT
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic             fin_r, fin_nxt;
  logic [3:0]       opcode_r, opcode_nxt;
  logic [3:0]       ext_left_r, ext_left_nxt;
  logic [LEN_W-1:0] len_acc_r, len_acc_nxt;
  logic             len_ovf_r, len_ovf_nxt;
  logic [LEN_W-1:0] payload_left_r, payload_left_nxt;
  logic [31:0]      mask_key_r, mask_key_nxt;
  logic [1:0]       mask_pos_r, mask_pos_nxt;
  logic [1:0]       open_type_r, open_type_nxt;
  logic [LEN_W-1:0] total_r, total_nxt;
  logic [LEN_W-1:0] max_bytes_r;
  logic             out_valid_r, out_valid_nxt;
  wsdf_out_t        out_data_r, out_data_nxt;

  logic             in_fire;
  logic [7:0]       b;
  phase_t           cur_phase;
  logic [1:0]       cur_type;
  logic [LEN_W-1:0] cur_total;
  logic             res_valid;
  wsdf_out_t        res;
  logic             fin_len;
  logic [LEN_W-1:0] fin_len_val;
  logic             fin_len_ovf;
  logic [LEN_W:0]   sum_total;
  logic             dlv;
  logic             dlv_has;
  logic [7:0]       dlv_byte;
  logic             dlv_first;
  logic             dlv_last;
  logic             dlv_done;
  logic [7:0]       key_byte;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign b        = in_data.rx_byte;

  // new_connection clears the parser ahead of this byte
  assign cur_phase = in_data.new_connection ? PH_HDR0 : phase_r;
  assign cur_type  = in_data.new_connection ? MSG_NONE : open_type_r;
  assign cur_total = in_data.new_connection ? '0 : total_r;

  assign key_byte  = mask_key_r[8*(3-mask_pos_r) +: 8];
  assign sum_total = {1'b0, cur_total} + {1'b0, fin_len_val};

  always_comb begin
    phase_nxt        = cur_phase;
    fin_nxt          = fin_r;
    opcode_nxt       = opcode_r;
    ext_left_nxt     = ext_left_r;
    len_acc_nxt      = len_acc_r;
    len_ovf_nxt      = len_ovf_r;
    payload_left_nxt = payload_left_r;
    mask_key_nxt     = mask_key_r;
    mask_pos_nxt     = mask_pos_r;
    open_type_nxt    = cur_type;
    total_nxt        = cur_total;
    res_valid        = 1'b0;
    res              = '0;
    fin_len          = 1'b0;
    fin_len_val      = len_acc_r;
    fin_len_ovf      = len_ovf_r;
    dlv              = 1'b0;
    dlv_has          = 1'b0;
    dlv_byte         = 8'd0;
    dlv_first        = 1'b0;
    dlv_last         = 1'b0;
    dlv_done         = 1'b0;

    case (cur_phase)
      PH_HDR0: begin
        fin_nxt    = b[7];
        opcode_nxt = b[3:0];
        phase_nxt  = PH_HDR1;
      end
      PH_HDR1: begin
        len_acc_nxt = '0;
        len_ovf_nxt = 1'b0;
        if (!b[7]) begin
          res_valid = 1'b1;
          res.kind  = KIND_VIOL;
          phase_nxt = PH_HALT;
        end else if (b[6:0] == LEN_CODE_16) begin
          ext_left_nxt = EXT_BYTES_16;
          phase_nxt    = PH_EXT;
        end else if (b[6:0] == LEN_CODE_64) begin
          ext_left_nxt = EXT_BYTES_64;
          phase_nxt    = PH_EXT;
        end else begin
          fin_len     = 1'b1;
          fin_len_val = {{(LEN_W-7){1'b0}}, b[6:0]};
          fin_len_ovf = 1'b0;
        end
      end
      PH_EXT: begin
        // anything shifted past the register width makes the frame oversize
        len_acc_nxt  = {len_acc_r[LEN_W-9:0], b};
        len_ovf_nxt  = len_ovf_r || (len_acc_r[LEN_W-1 -: 8] != 8'd0);
        ext_left_nxt = ext_left_r - 4'd1;
        if (ext_left_nxt == 4'd0) begin
          fin_len     = 1'b1;
          fin_len_val = len_acc_nxt;
          fin_len_ovf = len_ovf_nxt;
        end
      end
      PH_MASK: begin
        mask_key_nxt = {mask_key_r[23:0], b};
        mask_pos_nxt = mask_pos_r + 2'd1;
        if (mask_pos_nxt == 2'd0) begin
          if (payload_left_r == '0) begin
            dlv       = 1'b1;
            dlv_first = 1'b1;
            dlv_last  = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        mask_pos_nxt     = mask_pos_r + 2'd1;
        payload_left_nxt = payload_left_r - {{(LEN_W-1){1'b0}}, 1'b1};
        dlv              = 1'b1;
        dlv_has          = 1'b1;
        dlv_byte         = b ^ key_byte;
        dlv_first        = (payload_left_r == len_acc_r);
        dlv_last         = (payload_left_nxt == '0);
      end
      PH_HALT: begin
      end
      default: begin
        phase_nxt = PH_HALT;
      end
    endcase

    // length complete: limit checks, then on to the masking key
    if (fin_len) begin
      len_acc_nxt = fin_len_val;
      if (fin_len_ovf || (fin_len_val > max_bytes_r)) begin
        res_valid = 1'b1;
        res.kind  = KIND_VIOL;
        phase_nxt = PH_HALT;
      end else if (opcode_r == OP_CONT && cur_type != MSG_NONE &&
                   sum_total > {1'b0, max_bytes_r}) begin
        res_valid = 1'b1;
        res.kind  = KIND_VIOL;
        phase_nxt = PH_HALT;
      end else begin
        if (opcode_r == OP_CONT && cur_type != MSG_NONE) begin
          total_nxt = sum_total[LEN_W-1:0];
        end else if (opcode_r == OP_TEXT) begin
          open_type_nxt = MSG_TEXT;
          total_nxt     = fin_len_val;
        end else if (opcode_r == OP_BINARY) begin
          open_type_nxt = MSG_BINARY;
          total_nxt     = fin_len_val;
        end
        payload_left_nxt = fin_len_val;
        mask_key_nxt     = '0;
        mask_pos_nxt     = 2'd0;
        phase_nxt        = PH_MASK;
      end
    end

    if (dlv) begin
      dlv_done = dlv_last && fin_r;
      if (dlv_last) begin
        phase_nxt = PH_HDR0;
      end
      if (opcode_r == OP_TEXT || opcode_r == OP_BINARY) begin
        if (dlv_has || dlv_first) begin
          res_valid        = 1'b1;
          res.kind         = KIND_MSG;
          res.message_type = cur_type;
          res.has_byte     = dlv_has;
          res.data_byte    = dlv_byte;
          res.begins       = dlv_first;
          res.is_last      = dlv_done;
        end
        if (dlv_done) begin
          open_type_nxt = MSG_NONE;
          total_nxt     = '0;
        end
      end else if (opcode_r == OP_CONT && cur_type != MSG_NONE) begin
        if (dlv_has || dlv_done) begin
          res_valid        = 1'b1;
          res.kind         = KIND_MSG;
          res.message_type = cur_type;
          res.has_byte     = dlv_has;
          res.data_byte    = dlv_byte;
          res.is_last      = dlv_done;
        end
        if (dlv_done) begin
          open_type_nxt = MSG_NONE;
          total_nxt     = '0;
        end
      end else if (opcode_r == OP_PING) begin
        res_valid     = 1'b1;
        res.kind      = KIND_PING;
        res.has_byte  = dlv_has;
        res.data_byte = dlv_byte;
        res.is_last   = dlv_last;
      end else if (opcode_r == OP_CLOSE) begin
        // close payload is dropped; the event follows its last byte
        if (dlv_last) begin
          res_valid = 1'b1;
          res.kind  = KIND_CLOSE;
          phase_nxt = PH_HALT;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_fire) begin
      out_valid_nxt = res_valid;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HDR0;
      fin_r          <= 1'b0;
      opcode_r       <= OP_CONT;
      ext_left_r     <= '0;
      len_acc_r      <= '0;
      len_ovf_r      <= 1'b0;
      payload_left_r <= '0;
      mask_key_r     <= '0;
      mask_pos_r     <= '0;
      open_type_r    <= MSG_NONE;
      total_r        <= '0;
      max_bytes_r    <= MAX_MSG_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r        <= phase_nxt;
        fin_r          <= fin_nxt;
        opcode_r       <= opcode_nxt;
        ext_left_r     <= ext_left_nxt;
        len_acc_r      <= len_acc_nxt;
        len_ovf_r      <= len_ovf_nxt;
        payload_left_r <= payload_left_nxt;
        mask_key_r     <= mask_key_nxt;
        mask_pos_r     <= mask_pos_nxt;
        open_type_r    <= open_type_nxt;
        total_r        <= total_nxt;
      end
      if (cfg_we) begin
        max_bytes_r <= cfg_wdata;
      end
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEXT(a_halt_after_stop,
    in_fire && res_valid && (res.kind == KIND_VIOL || res.kind == KIND_CLOSE),
    phase_r == PH_HALT)
  `ASSERT_NOW(a_payload_nonempty, phase_r == PH_PAYLOAD, payload_left_r != '0)
  `ASSERT_NOW(a_begins_is_msg, out_valid_r && out_data_r.begins,
    out_data_r.kind == KIND_MSG && out_data_r.message_type != MSG_NONE)

endmodule
